[rtl/fslog_pkg.sv]
// Shared types and constants for the flash slot ring heading logger.
// No dependencies; compiled first.
package fslog_pkg;

  localparam int unsigned SlotCountDef = 256;
  localparam int unsigned SlotOutW     = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [15:0] PeriodRst = 16'd6000;
  localparam logic [15:0] MinRst    = 16'd100;
  localparam logic [15:0] DeltaRst  = 16'd100;
  localparam logic [14:0] LimitRst  = 15'd18000;

  typedef enum logic [1:0] {
    CMD_ERASE   = 2'd0,
    CMD_PROGRAM = 2'd1,
    CMD_REPORT  = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD = 2'd0,
    REG_MIN    = 2'd1,
    REG_DELTA  = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [15:0] period_ticks;
    logic [15:0] min_ticks;
    logic [15:0] delta_threshold;
    logic [14:0] yaw_limit;
  } cfg_t;

  typedef struct packed {
    cmd_e               command;
    logic [SlotOutW-1:0] slot;
    logic [15:0]        word;
    logic signed [15:0] restored_yaw;
    logic               restored_valid;
    logic               last;
  } res_t;

  // Results produced by one processed request, first in r0.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

[rtl/fslog_if.sv]
// Request and result channel interfaces for the heading logger.
// Depends on fslog_pkg.
interface fslog_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [31:0]        page_word;
  logic signed [15:0] yaw;

  modport source (output valid, action, page_word, yaw, input ready);
  modport sink   (input valid, action, page_word, yaw, output ready);
endinterface

interface fslog_out_if
  import fslog_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [SlotOutW-1:0] slot;
  logic [15:0]         word;
  logic signed [15:0]  restored_yaw;
  logic                restored_valid;
  logic                last;

  modport source (output valid, command, slot, word, restored_yaw, restored_valid, last,
                  input ready);
  modport sink   (input valid, command, slot, word, restored_yaw, restored_valid, last,
                  output ready);
endinterface

[rtl/fslog_core.sv]
// Input register, scan/tick decision logic and logger state.
// Depends on fslog_pkg.
module fslog_core
  import fslog_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SlotCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [31:0]        page_word_i,
  input  logic signed [15:0] yaw_i,
  input  logic               room_i,
  output push_t              push_o
);

  localparam int unsigned SlotW = $clog2(SLOT_COUNT + 1);

  logic               s1_valid_q;
  logic               s1_action_q;
  logic [31:0]        s1_word_q;
  logic signed [15:0] s1_yaw_q;

  logic               scanning_q, scanning_d;
  logic [15:0]        tick_q, tick_d;
  logic signed [15:0] lwy_q, lwy_d;
  logic [SlotW-1:0]   next_slot_q, next_slot_d;
  logic [31:0]        seen_q, seen_d;
  logic               seen_pres_q, seen_pres_d;

  logic               adv;
  logic [SlotW-1:0]   slot_inc;
  logic               scan_full, erased;
  logic [31:0]        eff_word;
  logic               eff_pres;
  logic signed [16:0] v17, mag17;
  logic               rvalid;
  logic signed [15:0] ryaw;
  logic [15:0]        tc_new;
  logic signed [16:0] diff17, delta17;
  logic               due, full;
  logic [SlotW-1:0]   prog_slot;
  logic [SlotW+7:0]   slot_ext;
  res_t               rep, ers, prg;

  assign adv        = s1_valid_q && room_i;
  assign in_ready_o = !s1_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_action_q <= action_i;
      s1_word_q   <= page_word_i;
      s1_yaw_q    <= yaw_i;
    end
  end

  // scan side
  assign slot_inc  = next_slot_q + 1'b1;
  assign scan_full = slot_inc >= SlotW'(SLOT_COUNT);
  assign erased    = s1_word_q == 32'hFFFF_FFFF;
  assign eff_word  = erased ? seen_q : s1_word_q;
  assign eff_pres  = erased ? seen_pres_q : 1'b1;
  assign v17       = {eff_word[15], eff_word[15:0]};
  assign mag17     = v17[16] ? -v17 : v17;
  assign rvalid    = eff_pres && (eff_word[31:16] == 16'd0)
                     && ($unsigned(mag17) <= {2'b00, cfg_i.yaw_limit});
  assign ryaw      = eff_pres ? $signed(eff_word[15:0]) : 16'sd0;

  // tick side
  assign tc_new   = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
  assign diff17   = {s1_yaw_q[15], s1_yaw_q} - {lwy_q[15], lwy_q};
  assign delta17  = diff17[16] ? -diff17 : diff17;
  assign due      = ((tc_new >= cfg_i.period_ticks)
                     || ($unsigned(delta17) > {1'b0, cfg_i.delta_threshold}))
                    && (tc_new >= cfg_i.min_ticks);
  assign full     = next_slot_q >= SlotW'(SLOT_COUNT);
  assign prog_slot = full ? '0 : next_slot_q;
  assign slot_ext  = {8'd0, prog_slot};

  always_comb begin
    rep = '0;
    rep.command        = CMD_REPORT;
    rep.restored_yaw   = ryaw;
    rep.restored_valid = rvalid;
    rep.last           = 1'b1;
    ers = '0;
    ers.command = CMD_ERASE;
    prg = '0;
    prg.command = CMD_PROGRAM;
    prg.slot    = slot_ext[SlotOutW-1:0];
    prg.word    = s1_yaw_q;
    prg.last    = 1'b1;
  end

  always_comb begin
    scanning_d  = scanning_q;
    tick_d      = tick_q;
    lwy_d       = lwy_q;
    next_slot_d = next_slot_q;
    seen_d      = seen_q;
    seen_pres_d = seen_pres_q;
    push_o      = '0;
    if (adv) begin
      if (!s1_action_q) begin
        if (scanning_q) begin
          if (!erased) begin
            seen_d      = s1_word_q;
            seen_pres_d = 1'b1;
            next_slot_d = slot_inc;
          end
          if (erased || scan_full) begin
            scanning_d = 1'b0;
            push_o.n   = 2'd1;
            push_o.r0  = rep;
            if (rvalid) begin
              lwy_d = $signed(eff_word[15:0]);
            end
          end
        end
      end else if (!scanning_q) begin
        tick_d = tc_new;
        if (due) begin
          tick_d      = 16'd0;
          lwy_d       = s1_yaw_q;
          next_slot_d = prog_slot + 1'b1;
          if (full) begin
            push_o.n  = 2'd2;
            push_o.r0 = ers;
            push_o.r1 = prg;
          end else begin
            push_o.n  = 2'd1;
            push_o.r0 = prg;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanning_q  <= 1'b1;
      tick_q      <= 16'd0;
      lwy_q       <= 16'sd0;
      next_slot_q <= '0;
      seen_q      <= 32'd0;
      seen_pres_q <= 1'b0;
    end else begin
      scanning_q  <= scanning_d;
      tick_q      <= tick_d;
      lwy_q       <= lwy_d;
      next_slot_q <= next_slot_d;
      seen_q      <= seen_d;
      seen_pres_q <= seen_pres_d;
    end
  end

endmodule

[rtl/fslog_outq.sv]
// Four-entry result queue, up to two pushes and one pop per cycle.
// Depends on fslog_pkg.
module fslog_outq
  import fslog_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  res_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   count_q;
  logic            pop;
  logic [PtrW-1:0] wptr1;

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rptr_q];
  assign pop     = valid_o && ready_i;
  assign room_o  = count_q <= (PtrW + 1)'(Depth - 2);
  assign wptr1   = wptr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wptr1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PtrW'(push_i.n);
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      count_q <= count_q + (PtrW + 1)'(push_i.n) - (PtrW + 1)'(pop);
    end
  end

endmodule

[rtl/flash_slot_ring_yaw_logger.sv]
// Top level of the flash slot ring heading logger: config registers, core, result queue.
// Depends on fslog_pkg, fslog_if, fslog_core, fslog_outq.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------
//  in_i     | in  | valid/ready      | action, page_word, yaw
//  out_o    | out | valid/ready      | command, slot, word, restored_yaw,
//           |     |                  | restored_valid, last
//  cfg      | in  | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// One request per cycle while the queue has room; a request is held in the input register,
// its results are written into the four-entry queue, which presents them on out_o in order.
// A tick that finds the page full yields an erase followed by a program.
// The input register holds while the queue has fewer than two free entries.
// Reset is immediate: no clearing pass; the block starts in the scan phase.
module flash_slot_ring_yaw_logger
  import fslog_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SlotCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fslog_in_if.sink            in_i,
  fslog_out_if.source         out_o
);

  cfg_t  cfg_q;
  push_t push;
  logic  room;
  res_t  head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ticks    <= PeriodRst;
      cfg_q.min_ticks       <= MinRst;
      cfg_q.delta_threshold <= DeltaRst;
      cfg_q.yaw_limit       <= LimitRst;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_PERIOD: cfg_q.period_ticks    <= cfg_data_i;
        REG_MIN:    cfg_q.min_ticks       <= cfg_data_i;
        REG_DELTA:  cfg_q.delta_threshold <= cfg_data_i;
        REG_LIMIT:  cfg_q.yaw_limit       <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  fslog_core #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .action_i    (in_i.action),
    .page_word_i (in_i.page_word),
    .yaw_i       (in_i.yaw),
    .room_i      (room),
    .push_o      (push)
  );

  fslog_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (head)
  );

  assign out_o.command        = head.command;
  assign out_o.slot           = head.slot;
  assign out_o.word           = head.word;
  assign out_o.restored_yaw   = head.restored_yaw;
  assign out_o.restored_valid = head.restored_valid;
  assign out_o.last           = head.last;

  // a double push is always erase followed by program
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n == 2'd2 |-> push.r0.command == CMD_ERASE && push.r1.command == CMD_PROGRAM
                       && !push.r0.last && push.r1.last)
    else $error("erase/program pair malformed");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n != 2'd3)
    else $error("too many results for one request");

  // nothing is pushed unless the queue had room
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n != 2'd0 |-> room)
    else $error("result pushed into full queue");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n == 2'd1 |-> push.r0.last)
    else $error("single result without last");

endmodule

[verif/slot_log_checker.sv]
// Watcher for the heading logger: keeps its own copy of the logger state, predicts the
// flash commands of every accepted request and compares them with the results.
// Depends on fslog_pkg and fslog_if.
module slot_log_checker
  import fslog_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fslog_in_if                 req_i,
  fslog_out_if                res_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotCount  = SlotCountDef;
  localparam logic [31:0] ErasedWord = 32'hFFFF_FFFF;

  // configuration copy
  logic [15:0] period_ticks;
  logic [15:0] min_ticks;
  logic [15:0] delta_thr;
  logic [14:0] yaw_limit;

  // logger state
  logic               scanning;
  logic [15:0]        tick_ctr;
  logic signed [15:0] written_yaw;
  int                 next_slot;
  logic [31:0]        seen_word;
  logic               seen_present;

  res_t flash_cmds_q[$];
  res_t want;

  task automatic advance_logger(input logic act, input logic [31:0] pw,
                                input logic signed [15:0] yaw);
    res_t r;
    int   diff;
    int   mag;
    logic scan_done;
    scan_done = 1'b0;
    if (!act) begin
      if (scanning) begin
        if (pw == ErasedWord) begin
          scan_done = 1'b1;
        end else begin
          seen_word    = pw;
          seen_present = 1'b1;
          next_slot++;
          scan_done = (next_slot >= SlotCount);
        end
      end
    end else if (!scanning) begin
      if (tick_ctr != 16'hFFFF) tick_ctr++;
      diff = int'(yaw) - int'(written_yaw);
      if (diff < 0) diff = -diff;
      if ((tick_ctr >= period_ticks || diff > int'(delta_thr)) && tick_ctr >= min_ticks) begin
        tick_ctr = '0;
        // full page: erase comes first, then the program into slot 0
        if (next_slot >= SlotCount) begin
          r = '0;
          r.command = CMD_ERASE;
          flash_cmds_q.push_back(r);
          next_slot = 0;
        end
        r = '0;
        r.command = CMD_PROGRAM;
        r.slot    = next_slot[SlotOutW-1:0];
        r.word    = yaw;
        r.last    = 1'b1;
        flash_cmds_q.push_back(r);
        written_yaw = yaw;
        next_slot++;
      end
    end
    if (scan_done) begin
      scanning = 1'b0;
      r = '0;
      r.command = CMD_REPORT;
      r.last    = 1'b1;
      if (seen_present) begin
        r.restored_yaw = seen_word[15:0];
        mag = int'(r.restored_yaw);
        if (mag < 0) mag = -mag;
        if (seen_word[31:16] == 16'h0 && mag <= int'(yaw_limit)) begin
          r.restored_valid = 1'b1;
          written_yaw = r.restored_yaw;
        end
      end
      flash_cmds_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_ticks = PeriodRst;
      min_ticks    = MinRst;
      delta_thr    = DeltaRst;
      yaw_limit    = LimitRst;
      scanning     = 1'b1;
      tick_ctr     = '0;
      written_yaw  = '0;
      next_slot    = 0;
      seen_word    = '0;
      seen_present = 1'b0;
      flash_cmds_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_PERIOD: period_ticks = cfg_data_i;
          REG_MIN:    min_ticks    = cfg_data_i;
          REG_DELTA:  delta_thr    = cfg_data_i;
          REG_LIMIT:  yaw_limit    = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        advance_logger(req_i.action, req_i.page_word, req_i.yaw);
      end
      if (res_i.valid && res_i.ready) begin
        if (flash_cmds_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual command %0d slot %0d word %0d",
                   $time, res_i.command, res_i.slot, res_i.word);
          fail_count_o++;
        end else begin
          want = flash_cmds_q.pop_front();
          check_field("command", int'(want.command), int'(res_i.command));
          check_field("slot", int'(want.slot), int'(res_i.slot));
          check_field("word", int'(want.word), int'(res_i.word));
          check_field("restored_yaw", int'(want.restored_yaw), int'(res_i.restored_yaw));
          check_field("restored_valid", int'(want.restored_valid), int'(res_i.restored_valid));
          check_field("last", int'(want.last), int'(res_i.last));
        end
      end
      pending_o = flash_cmds_q.size();
    end
  end

endmodule

[verif/testbench.sv]
// Top of the heading logger testbench: clock, reset, request and config stimulus,
// receiver stalls and the verdict. Depends on fslog_pkg, fslog_if, the logger RTL
// and slot_log_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fslog_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SlotCount  = SlotCountDef;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int          tx_idle;
  int          rx_idle;
  bit          burst_req = 1'b0;
  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  int          prev_yaw;
  logic [15:0] cur_delta;

  fslog_in_if  req_if ();
  fslog_out_if res_if ();

  flash_slot_ring_yaw_logger dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  slot_log_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL flash_slot_ring_yaw_logger");
      $finish;
    end
  end

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (burst_req) begin
        burst_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  function automatic int rand_yaw();
    return int'($urandom_range(36000)) - 18000;
  endfunction

  // Offer one request; returns right after the edge that accepted it.
  task automatic send_req(input logic act, input logic [31:0] pw,
                          input logic signed [15:0] yaw);
    logic took;
    while ($urandom_range(99) < tx_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= act;
    req_if.page_word <= pw;
    req_if.yaw       <= yaw;
    do begin
      @(negedge clk);
      took = req_if.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Wait until every predicted command has come out and the input stage is empty.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] period, input logic [15:0] min_cnt,
                            input logic [15:0] delta, input logic [14:0] limit);
    cur_delta = delta;
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_PERIOD;
    cfg_data <= period;
    @(posedge clk);
    cfg_idx  <= REG_MIN;
    cfg_data <= min_cnt;
    @(posedge clk);
    cfg_idx  <= REG_DELTA;
    cfg_data <= delta;
    @(posedge clk);
    cfg_idx  <= REG_LIMIT;
    cfg_data <= {1'b0, limit};
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic rand_config();
    logic [15:0] period;
    logic [15:0] min_cnt;
    logic [15:0] delta;
    case ($urandom_range(3))
      0:       period = 16'd0;
      1:       period = 16'd1;
      default: period = 16'($urandom_range(2, 30));
    endcase
    min_cnt = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 12));
    case ($urandom_range(3))
      0:       delta = 16'd0;
      1:       delta = 16'd36000;
      default: delta = 16'($urandom_range(1, 1500));
    endcase
    set_config(period, min_cnt, delta, 15'($urandom_range(18000)));
  endtask

  // Mostly ticks: headings near the last one, uniform, or at the extremes.
  // Scan words after the scan are noise and do not count.
  task automatic run_random(input int n);
    int ticks_sent;
    int y;
    int spread;
    ticks_sent = 0;
    while (ticks_sent < n) begin
      if ($urandom_range(19) == 0) begin
        send_req(1'b0, $urandom_range(1) ? 32'hFFFF_FFFF : $urandom, 16'(rand_yaw()));
      end else begin
        spread = int'(cur_delta) + 50;
        case ($urandom_range(9))
          0:          y = ($urandom_range(1)) ? -18000 : 18000;
          1:          y = 0;
          2, 3, 4, 5: y = prev_yaw + int'($urandom_range(2 * spread)) - spread;
          default:    y = rand_yaw();
        endcase
        if (y > 18000) y = 18000;
        if (y < -18000) y = -18000;
        send_req(1'b1, $urandom, 16'(y));
        prev_yaw = y;
        ticks_sent++;
      end
    end
  endtask

  initial begin
    int          lim;
    int          mode;
    int          len;
    int          kind;
    int          mag;
    int          v;
    logic [15:0] upper;
    logic [31:0] w;
    int          yaws[$];

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_PERIOD;
    cfg_data         = '0;
    req_if.valid     = 1'b0;
    req_if.action    = 1'b0;
    req_if.page_word = '0;
    req_if.yaw       = '0;
    tx_idle          = 15;
    rx_idle          = 71;
    prev_yaw         = 0;
    cur_delta        = DeltaRst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    case ($urandom_range(2))
      0:       lim = 0;
      1:       lim = 18000;
      default: lim = $urandom_range(1, 17999);
    endcase
    set_config(PeriodRst, MinRst, DeltaRst, 15'(lim));

    // Scan: no stored word, a valid last word, one with upper bits set,
    // one beyond the limit, or a page with no erased word at all.
    mode = $urandom_range(4);
    if (mode == 0) len = 0;
    else if (mode == 4) len = SlotCount;
    else len = $urandom_range(1, SlotCount - 1);
    kind = (mode == 4) ? $urandom_range(1, 3) : mode;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_req(1'b1, $urandom, 16'(rand_yaw()));
      w = $urandom;
      if (w == 32'hFFFF_FFFF) w = '0;
      if (i == len - 1) begin
        case (kind)
          1: begin
            mag = $urandom_range(1) ? lim : $urandom_range(lim);
            v   = $urandom_range(1) ? -mag : mag;
            w   = {16'h0, 16'(v)};
          end
          2: begin
            v     = int'($urandom_range(2 * lim)) - lim;
            upper = 16'($urandom_range(1, 65535));
            w     = {upper, 16'(v)};
            if (w == 32'hFFFF_FFFF) w[15:0] = '0;
          end
          default: begin
            mag = $urandom_range(lim + 1, 32768);
            v   = (mag == 32768 || $urandom_range(1)) ? -mag : mag;
            w   = {16'h0, 16'(v)};
          end
        endcase
      end
      send_req(1'b0, w, '0);
    end
    if (mode != 4) send_req(1'b0, 32'hFFFF_FFFF, '0);
    // scan words after the scan are ignored
    send_req(1'b0, $urandom, '0);
    send_req(1'b0, 32'hFFFF_FFFF, '0);

    // Directed: period, min count and threshold boundaries, extreme headings.
    settle();
    set_config(16'd3, 16'd2, 16'd100, 15'(lim));
    yaws = '{0, 0, 0, 18000, -18000, 18000, 18000, 100, 201, 302, 0, 0};
    foreach (yaws[i]) send_req(1'b1, $urandom, 16'(yaws[i]));
    settle();
    // zero period: every tick writes
    set_config(16'd0, 16'd0, 16'd0, 15'd0);
    yaws = '{-1, 1, 1, -18000};
    foreach (yaws[i]) send_req(1'b1, $urandom, 16'(yaws[i]));
    settle();
    // full swing equals the largest threshold, which is not exceeded
    set_config(16'hFFFF, 16'd0, 16'd36000, 15'd18000);
    yaws = '{-18000, 18000, -18000};
    foreach (yaws[i]) send_req(1'b1, $urandom, 16'(yaws[i]));
    send_req(1'b0, 32'hFFFF_FFFF, '0);
    send_req(1'b0, '0, '0);

    settle();
    rand_config();
    run_random(60);

    settle();
    tx_idle = 71;
    rx_idle = 15;
    rand_config();
    run_random(60);

    // Every tick writes, so the page wraps; the receiver holds off meanwhile.
    settle();
    set_config(16'd1, 16'd0, 16'($urandom_range(36000)), 15'd18000);
    tx_idle   = 0;
    rx_idle   = 0;
    burst_req = 1'b1;
    run_random(260);

    settle();
    rand_config();
    run_random(60);

    // Largest period and min count: no write before the full count.
    settle();
    set_config(16'hFFFF, 16'hFFFF, 16'd0, 15'd18000);
    repeat (20) send_req(1'b1, $urandom, 16'(rand_yaw()));

    settle();
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS flash_slot_ring_yaw_logger");
    end else begin
      $display("FAIL flash_slot_ring_yaw_logger");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fslog_pkg.sv
rtl/fslog_if.sv
rtl/fslog_core.sv
rtl/fslog_outq.sv
rtl/flash_slot_ring_yaw_logger.sv
verif/slot_log_checker.sv
verif/testbench.sv
